FILE: sv/bss_pkg.sv
`timescale 1ns / 1ps

package bss_pkg;

    // register file geometry
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int RANGE_W = 6;
    localparam int REG_IDX_W = 2;

    localparam logic [RANGE_W-1:0] RANGE_FIRST_RST = 6'd0;
    localparam logic [RANGE_W-1:0] RANGE_LAST_RST  = 6'd63;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SORT_MODE   = 2'd0,
        REG_RANGE_FIRST = 2'd1,
        REG_RANGE_LAST  = 2'd2
    } reg_idx_t;

    typedef enum logic {
        MODE_WHOLE    = 1'b0,
        MODE_SUBRANGE = 1'b1
    } sort_mode_t;

    typedef logic signed [7:0] char_t;

    typedef struct packed {
        sort_mode_t         sort_mode;
        logic [RANGE_W-1:0] range_first;
        logic [RANGE_W-1:0] range_last;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_FIRST,
        ST_PASS,
        ST_TAIL,
        ST_EMIT
    } state_t;

endpackage

FILE: sv/bss_cfg_regs.sv
`timescale 1ns / 1ps

module bss_cfg_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bss_pkg::ADDR_W-1:0] paddr,
    input  logic [bss_pkg::DATA_W-1:0] pwdata,
    output logic [bss_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bss_pkg::cfg_t              cfg
);

    bss_pkg::cfg_t     cfg_reg;
    bss_pkg::cfg_t     cfg_next;
    bss_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = bss_pkg::reg_idx_t'(paddr[bss_pkg::ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                bss_pkg::REG_SORT_MODE:
                    cfg_next.sort_mode = bss_pkg::sort_mode_t'(pwdata[0]);
                bss_pkg::REG_RANGE_FIRST:
                    cfg_next.range_first = pwdata[bss_pkg::RANGE_W-1:0];
                bss_pkg::REG_RANGE_LAST:
                    cfg_next.range_last = pwdata[bss_pkg::RANGE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sort_mode   <= bss_pkg::MODE_WHOLE;
            cfg_reg.range_first <= bss_pkg::RANGE_FIRST_RST;
            cfg_reg.range_last  <= bss_pkg::RANGE_LAST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, unused bits as zero
    always_comb
    begin
        unique case (idx)
            bss_pkg::REG_SORT_MODE:
                prdata = bss_pkg::DATA_W'(cfg_reg.sort_mode);
            bss_pkg::REG_RANGE_FIRST:
                prdata = bss_pkg::DATA_W'(cfg_reg.range_first);
            bss_pkg::REG_RANGE_LAST:
                prdata = bss_pkg::DATA_W'(cfg_reg.range_last);
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: sv/byte_string_sorter.sv
`timescale 1ns / 1ps

// byte string sorter: a string is loaded one beat per cycle through start/busy
// (busy low means a beat is taken whenever start is high); the beat with
// in_last set closes the string and busy rises once that beat is taken. the
// stored bytes are then put in ascending signed order by a single comparator
// that makes bubble passes over a store with one write and one read port:
// each pass is one shorter than the one before, and sorting stops after the
// first pass that moves nothing. the result is then streamed out one byte per
// cycle with valid high on every byte and out_last on the final one; the
// receiver cannot stall the stream, so it must take every beat as it comes.
// busy falls in the cycle after out_last. in subrange mode only bytes
// range_first..range_last are sorted; if range_last is not below the loaded
// length the string comes back unchanged with range_error set on every beat.
// bytes beyond MAX_LEN are dropped. the configuration registers (sort_mode at
// 0x0, range_first at 0x4, range_last at 0x8) must only be written while busy
// is low.
module byte_string_sorter
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // apb configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bss_pkg::ADDR_W-1:0] paddr,
    input  logic [bss_pkg::DATA_W-1:0] pwdata,
    output logic [bss_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // load side
    input  logic                       start,
    output logic                       busy,
    input  logic signed [7:0]          char_in,
    input  logic                       in_last,
    // result side
    output logic                       valid,
    output logic signed [7:0]          char_out,
    output logic                       out_last,
    output logic                       range_error
);

    // address into the store, and count that can hold MAX_LEN itself
    localparam int AW   = $clog2(MAX_LEN);
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int CMPW = (CW > bss_pkg::RANGE_W) ? CW : bss_pkg::RANGE_W;

    bss_pkg::cfg_t   cfg;

    bss_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   lo_reg,    lo_next;
    logic [AW-1:0]   hi_reg,    hi_next;
    logic [AW-1:0]   ptr_reg,   ptr_next;
    bss_pkg::char_t  carry_reg, carry_next;
    logic            swap_reg,  swap_next;
    logic            err_reg,   err_next;

    // byte store, one write and one registered read per cycle
    bss_pkg::char_t  mem [MAX_LEN];
    bss_pkg::char_t  rdata_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    bss_pkg::char_t  wdata;

    logic            emit_last;

    bss_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // emission index has reached the final loaded byte
    assign emit_last = ((CW'(ptr_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ptr_next   = ptr_reg;
        carry_next = carry_reg;
        swap_next  = swap_reg;
        err_next   = err_reg;
        we         = 1'b0;
        waddr      = ptr_reg - AW'(1);
        wdata      = carry_reg;
        raddr      = ptr_reg;

        unique case (state_reg)
            bss_pkg::ST_LOAD:
            begin
                if (start)
                begin
                    // bytes past the end of the store are dropped
                    if (count_reg < CW'(MAX_LEN))
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[AW-1:0];
                        wdata      = char_in;
                        count_next = count_reg + CW'(1);
                    end
                    if (in_last)
                    begin
                        state_next = bss_pkg::ST_SETUP;
                    end
                end
            end

            bss_pkg::ST_SETUP:
            begin
                err_next = 1'b0;
                if (cfg.sort_mode == bss_pkg::MODE_WHOLE)
                begin
                    lo_next = '0;
                    hi_next = AW'(count_reg - CW'(1));
                end
                else
                begin
                    lo_next = AW'(cfg.range_first);
                    hi_next = AW'(cfg.range_last);
                end

                priority if (cfg.sort_mode == bss_pkg::MODE_WHOLE && count_reg > CW'(1))
                begin
                    raddr      = lo_next;
                    state_next = bss_pkg::ST_FIRST;
                end
                else if (cfg.sort_mode == bss_pkg::MODE_SUBRANGE
                         && CMPW'(cfg.range_last) >= CMPW'(count_reg))
                begin
                    // range runs past the string: emit unchanged, flagged
                    err_next   = 1'b1;
                    raddr      = '0;
                    ptr_next   = '0;
                    state_next = bss_pkg::ST_EMIT;
                end
                else if (cfg.sort_mode == bss_pkg::MODE_SUBRANGE
                         && cfg.range_first < cfg.range_last)
                begin
                    raddr      = lo_next;
                    state_next = bss_pkg::ST_FIRST;
                end
                else
                begin
                    raddr      = '0;
                    ptr_next   = '0;
                    state_next = bss_pkg::ST_EMIT;
                end
            end

            bss_pkg::ST_FIRST:
            begin
                // first byte of the pass becomes the running maximum
                carry_next = rdata_reg;
                ptr_next   = lo_reg + AW'(1);
                raddr      = lo_reg + AW'(1);
                swap_next  = 1'b0;
                state_next = bss_pkg::ST_PASS;
            end

            bss_pkg::ST_PASS:
            begin
                we    = 1'b1;
                waddr = ptr_reg - AW'(1);
                if (rdata_reg < carry_reg)
                begin
                    wdata     = rdata_reg;
                    swap_next = 1'b1;
                end
                else
                begin
                    wdata      = carry_reg;
                    carry_next = rdata_reg;
                end

                if (ptr_reg == hi_reg)
                begin
                    raddr      = lo_reg;
                    state_next = bss_pkg::ST_TAIL;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                    raddr    = ptr_reg + AW'(1);
                end
            end

            bss_pkg::ST_TAIL:
            begin
                // maximum settles at the top of the span
                we    = 1'b1;
                waddr = hi_reg;
                wdata = carry_reg;
                if (!swap_reg || (hi_reg - AW'(1)) == lo_reg)
                begin
                    raddr      = '0;
                    ptr_next   = '0;
                    state_next = bss_pkg::ST_EMIT;
                end
                else
                begin
                    hi_next    = hi_reg - AW'(1);
                    raddr      = lo_reg;
                    state_next = bss_pkg::ST_FIRST;
                end
            end

            bss_pkg::ST_EMIT:
            begin
                if (emit_last)
                begin
                    count_next = '0;
                    raddr      = '0;
                    state_next = bss_pkg::ST_LOAD;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                    raddr    = ptr_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = bss_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bss_pkg::ST_LOAD;
            count_reg <= '0;
            swap_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            swap_reg  <= swap_next;
            err_reg   <= err_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        ptr_reg   <= ptr_next;
        carry_reg <= carry_next;
    end

    assign busy        = (state_reg != bss_pkg::ST_LOAD);
    assign valid       = (state_reg == bss_pkg::ST_EMIT);
    assign char_out    = rdata_reg;
    assign out_last    = valid & emit_last;
    assign range_error = valid & err_reg;

    // result beats only come while the load side is held off
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result beat while not busy");

    // the final beat hands control back to loading
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && out_last) |=> (!busy && count_reg == '0))
        else $error("emission did not end after the final beat");

    // an error flag only comes from a subrange request
    a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && range_error) |-> (cfg.sort_mode == bss_pkg::MODE_SUBRANGE))
        else $error("range error in whole mode");

    // the scan pointer stays above the start of the active span and no higher than its top
    a_pass_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bss_pkg::ST_PASS) |-> (ptr_reg > lo_reg && ptr_reg <= hi_reg))
        else $error("scan pointer left the span");

endmodule
